FILE: hdl/xcfr_pkg.sv
// Shared constants and types for the XOR-checked frame receiver.
package xcfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Configuration register indexes
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  localparam byte_t START_RESET = 8'h65;
  localparam byte_t END_RESET   = 8'h0D;

endpackage

FILE: hdl/xor_checked_frame_receiver.sv
// Frame receiver: start marker, length, payload, XOR check byte, end marker; replays payload.
// One received byte is accepted per cycle while a frame is being parsed.
// After a good end marker the input stalls while the payload buffer (a 64 x 8
// synchronous RAM, one read port) replays. It gives one result per cycle while the
// output is not held off; the first result passes through the RAM read register and
// then the output register. The input stalls until the last read is issued (a single
// read for an empty frame). Synchronous active-high reset returns to hunting, clears
// out_valid and restores the marker registers; the payload RAM is not cleared.
module xor_checked_frame_receiver (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  xcfr_pkg::byte_t cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  xcfr_pkg::byte_t rx_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output xcfr_pkg::byte_t payload_byte,
  output logic           last_byte,
  output logic           empty_frame
);
  import xcfr_pkg::*;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CHK    = 3'd3;
  localparam logic [2:0] PH_END    = 3'd4;
  localparam logic [2:0] PH_REPLAY = 3'd5;

  byte_t       start_marker;
  byte_t       end_marker;
  logic [2:0]  phase;
  cnt_t        frame_length;
  cnt_t        bytes_stored;
  byte_t       running_xor;
  cnt_t        rd_idx;
  logic        rd_pend;
  logic        rd_last;
  logic        rd_empty;
  byte_t       mem_q;
  byte_t       mem [MAX_PAYLOAD];

  logic        in_fire;
  logic        load_out;
  logic        issue;
  logic        issue_last;
  cnt_t        stored_next;

  assign in_ready    = (phase != PH_REPLAY);
  assign in_fire     = in_valid && in_ready;
  assign load_out    = rd_pend && (!out_valid || out_ready);
  assign issue       = (phase == PH_REPLAY) && (!rd_pend || load_out);
  assign issue_last  = (frame_length == '0) || (rd_idx + cnt_t'(1) == frame_length);
  assign stored_next = bytes_stored + cnt_t'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_RESET;
      end_marker   <= END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START: start_marker <= cfg_data;
        REG_END:   end_marker   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Payload RAM: write while storing, read during replay
  always_ff @(posedge clk) begin
    if (in_fire && phase == PH_DATA && bytes_stored < cnt_t'(MAX_PAYLOAD)) begin
      mem[bytes_stored[ADDR_W-1:0]] <= rx_byte;
    end
    if (issue) begin
      mem_q <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  // Parse and replay control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      bytes_stored <= '0;
      running_xor  <= '0;
      rd_idx       <= '0;
      rd_pend      <= 1'b0;
      rd_last      <= 1'b0;
      rd_empty     <= 1'b0;
    end else begin
      if (issue) begin
        rd_pend  <= 1'b1;
        rd_last  <= issue_last;
        rd_empty <= (frame_length == '0);
        rd_idx   <= rd_idx + cnt_t'(1);
        if (issue_last) begin
          phase <= PH_HUNT;
        end
      end else if (load_out) begin
        rd_pend <= 1'b0;
      end

      if (in_fire) begin
        unique case (phase)
          PH_LEN: begin
            if (rx_byte > byte_t'(MAX_PAYLOAD)) begin
              phase <= PH_HUNT;
            end else begin
              frame_length <= rx_byte[CNT_W-1:0];
              bytes_stored <= '0;
              running_xor  <= running_xor ^ rx_byte;
              phase        <= (rx_byte == '0) ? PH_CHK : PH_DATA;
            end
          end
          PH_DATA: begin
            bytes_stored <= stored_next;
            running_xor  <= running_xor ^ rx_byte;
            if (stored_next >= frame_length) begin
              phase <= PH_CHK;
            end
          end
          PH_CHK: begin
            phase <= (rx_byte == running_xor) ? PH_END : PH_HUNT;
          end
          PH_END: begin
            // start replay only on a matching end marker
            if (rx_byte == end_marker) begin
              phase  <= PH_REPLAY;
              rd_idx <= '0;
            end else begin
              phase <= PH_HUNT;
            end
          end
          default: begin
            if (rx_byte == start_marker) begin
              running_xor <= rx_byte;
              phase       <= PH_LEN;
            end else begin
              phase <= PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      payload_byte <= rd_empty ? '0 : mem_q;
      last_byte    <= rd_last;
      empty_frame  <= rd_empty;
    end
  end

endmodule

FILE: hdl/xcfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module xcfr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input xcfr_pkg::byte_t payload_byte,
  input logic            last_byte,
  input logic            empty_frame
);
  import xcfr_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("receiver not idle after reset");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |-> last_byte && payload_byte == '0)
    else $error("empty frame result must be last with zero payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(payload_byte) && $stable(last_byte) && $stable(empty_frame))
    else $error("result changed while stalled");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .last_byte    (last_byte),
  .empty_frame  (empty_frame)
);
